@@ sv/cmtc_pkg.sv @@
// shared types and codes for the comment line classifier
package cmtc_pkg;

  localparam int unsigned DEF_MAX_DELIM  = 8;
  localparam int unsigned DEF_COUNT_BITS = 32;

  localparam int unsigned REG_WIDTH = 64;
  localparam int unsigned LEN_WIDTH = 4;
  localparam int unsigned IDX_WIDTH = 3;
  localparam int unsigned TOT_WIDTH = 32;
  localparam int unsigned SAT_WIDTH = 4;

  localparam logic [SAT_WIDTH-1:0] SAT_MAX = '1;

  typedef enum logic [1:0] {
    OP_TEXT = 2'd0,
    OP_EOL  = 2'd1,
    OP_FILE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CLS_BLANK   = 2'd0,
    CLS_COMMENT = 2'd1,
    CLS_CODE    = 2'd2
  } class_e;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_LINE_PREFIX     = 3'd0,
    REG_LINE_PREFIX_LEN = 3'd1,
    REG_OPEN_DELIM      = 3'd2,
    REG_OPEN_LEN        = 3'd3,
    REG_CLOSE_DELIM     = 3'd4,
    REG_CLOSE_LEN       = 3'd5,
    REG_BLOCK_ENABLED   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [REG_WIDTH-1:0] line_prefix;
    logic [LEN_WIDTH-1:0] line_prefix_len;
    logic [REG_WIDTH-1:0] open_delim;
    logic [LEN_WIDTH-1:0] open_len;
    logic [REG_WIDTH-1:0] close_delim;
    logic [LEN_WIDTH-1:0] close_len;
    logic                 block_enabled;
  } cfg_t;

  typedef struct packed {
    logic [TOT_WIDTH-1:0] code_total;
    logic [TOT_WIDTH-1:0] comment_total;
    logic [TOT_WIDTH-1:0] blank_total;
    logic                 in_block;
    class_e               line_class;
  } result_t;

  localparam int unsigned RES_WIDTH   = $bits(result_t);
  localparam int unsigned RES_T_WIDTH = ((RES_WIDTH + 7) / 8) * 8;

endpackage

@@ sv/comment_line_classifier.sv @@
// top level: config registers, input word register, result register
//
//  channel   dir  tdata                                         tuser
//  s_axis    in   [7:0] character                               [1:0] op
//  m_axis    out  [1:0] class, [2] in_block, [34:3] blank,      -
//                 [66:35] comment, [98:67] code, rest zero
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)  -
//
// one word per cycle while the result register is not stalled: a word waits in
// the input register, is scanned against the line state in a single pass and a
// line end loads the result register, from which the result is offered.
// reset restores the default delimiters and clears all line state and counts.
// a stalled result register holds a line end word in the input register; the
// input side keeps flowing while the result register can accept or the word
// gives no result.
module comment_line_classifier #(
  parameter int unsigned MAX_DELIM  = cmtc_pkg::DEF_MAX_DELIM,
  parameter int unsigned COUNT_BITS = cmtc_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,  // character
  input  logic [1:0]                          s_axis_tuser_i,  // op
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // line_class, in_block, blank_total, comment_total, code_total, zero pad
  output logic [cmtc_pkg::RES_T_WIDTH-1:0]    m_axis_tdata_o,
  input  logic                                cfg_we_i,
  input  logic [cmtc_pkg::IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [cmtc_pkg::REG_WIDTH-1:0]      cfg_data_i
);

  cmtc_pkg::cfg_t    cfg_q;
  cmtc_pkg::result_t res, out_q;
  logic              in_valid_q, out_valid_q, adv, res_valid;
  logic [1:0]        in_op_q;
  logic [7:0]        in_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_prefix     <= 64'd12079;
      cfg_q.line_prefix_len <= 4'd2;
      cfg_q.open_delim      <= 64'd10799;
      cfg_q.open_len        <= 4'd2;
      cfg_q.close_delim     <= 64'd12074;
      cfg_q.close_len       <= 4'd2;
      cfg_q.block_enabled   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cmtc_pkg::reg_idx_e'(cfg_idx_i))
        cmtc_pkg::REG_LINE_PREFIX:     cfg_q.line_prefix     <= cfg_data_i;
        cmtc_pkg::REG_LINE_PREFIX_LEN: cfg_q.line_prefix_len <= cfg_data_i[3:0];
        cmtc_pkg::REG_OPEN_DELIM:      cfg_q.open_delim      <= cfg_data_i;
        cmtc_pkg::REG_OPEN_LEN:        cfg_q.open_len        <= cfg_data_i[3:0];
        cmtc_pkg::REG_CLOSE_DELIM:     cfg_q.close_delim     <= cfg_data_i;
        cmtc_pkg::REG_CLOSE_LEN:       cfg_q.close_len       <= cfg_data_i[3:0];
        cmtc_pkg::REG_BLOCK_ENABLED:   cfg_q.block_enabled   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a word moves on when it gives no result or the result register is free
  assign adv = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q   <= s_axis_tuser_i;
      in_char_q <= s_axis_tdata_i;
    end
  end

  cmtc_core #(.MAX_DELIM(MAX_DELIM), .COUNT_BITS(COUNT_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .op_i        (in_op_q),
    .char_i      (in_char_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = cmtc_pkg::RES_T_WIDTH'(out_q);

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  a_result_from_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_valid) |-> (in_op_q == cmtc_pkg::OP_EOL))
    else $error("result produced by a word that is not a line end");

  a_load_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_valid) |=> out_valid_q)
    else $error("loaded result not presented");

  a_class_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.line_class != 2'd3))
    else $error("illegal line class");

endmodule

@@ sv/cmtc_match.sv @@
// compares the newest bytes of the byte window against a delimiter
module cmtc_match #(
  parameter int unsigned MAX_DELIM = cmtc_pkg::DEF_MAX_DELIM,
  localparam int unsigned WIN_W = 8 * MAX_DELIM,
  localparam int unsigned LW = $clog2(MAX_DELIM + 1)
) (
  input  logic [WIN_W-1:0]               window_i,
  input  logic [cmtc_pkg::REG_WIDTH-1:0] delim_i,
  input  logic [LW-1:0]                  len_i,
  output logic                           match_o
);

  logic [MAX_DELIM:0] hit;

  assign hit[0] = 1'b0;

  for (genvar l = 1; l <= MAX_DELIM; l++) begin : g_len
    assign hit[l] = (window_i[WIN_W-1 -: 8*l] == delim_i[8*l-1:0]);
  end

  assign match_o = hit[len_i];

endmodule

@@ sv/cmtc_core.sv @@
// per-line scan state, line classing and running counts
module cmtc_core #(
  parameter int unsigned MAX_DELIM  = cmtc_pkg::DEF_MAX_DELIM,
  parameter int unsigned COUNT_BITS = cmtc_pkg::DEF_COUNT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [1:0]         op_i,
  input  logic [7:0]         char_i,
  input  cmtc_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output cmtc_pkg::result_t  res_o
);

  localparam int unsigned WIN_W = 8 * MAX_DELIM;
  localparam int unsigned LW = $clog2(MAX_DELIM + 1);
  localparam int unsigned SW = cmtc_pkg::SAT_WIDTH;
  localparam int unsigned TW = cmtc_pkg::TOT_WIDTH;
  localparam logic [cmtc_pkg::LEN_WIDTH-1:0] MAX_LEN = cmtc_pkg::LEN_WIDTH'(MAX_DELIM);

  logic             in_block_q, in_block_d;
  logic [WIN_W-1:0] win_q, win_d;
  logic             seen_q, seen_d;
  logic [SW-1:0]    lead_q, lead_d;
  logic             pline_q, pline_d;
  logic             popen_q, popen_d;
  logic             open_q, open_d;
  logic [SW-1:0]    since_q, since_d;
  logic             close_q, close_d;
  logic             tac_q, tac_d;
  logic [COUNT_BITS-1:0] blank_q, blank_d, comment_q, comment_d, code_q, code_d;

  logic [LW-1:0] pl, ol, cl;
  logic          m_line, m_open, m_close, ws;
  cmtc_pkg::class_e cls;
  logic          next_block;

  logic [COUNT_BITS+TW-1:0] blank_x, comment_x, code_x;

  function automatic logic [LW-1:0] clamp(input logic [cmtc_pkg::LEN_WIDTH-1:0] len);
    clamp = (len > MAX_LEN) ? LW'(MAX_DELIM) : len[LW-1:0];
  endfunction

  assign pl = clamp(cfg_i.line_prefix_len);
  assign ol = clamp(cfg_i.open_len);
  assign cl = clamp(cfg_i.close_len);

  // window after this byte shifts in, newest byte on top
  logic [WIN_W+7:0] win_cat;
  assign win_cat = {char_i, win_q};
  assign win_d   = win_cat[WIN_W+7:8];

  assign ws = (char_i == 8'h20) || (char_i >= 8'h09 && char_i <= 8'h0d);

  cmtc_match #(.MAX_DELIM(MAX_DELIM)) u_line_match (
    .window_i(win_d), .delim_i(cfg_i.line_prefix), .len_i(pl), .match_o(m_line)
  );
  cmtc_match #(.MAX_DELIM(MAX_DELIM)) u_open_match (
    .window_i(win_d), .delim_i(cfg_i.open_delim), .len_i(ol), .match_o(m_open)
  );
  cmtc_match #(.MAX_DELIM(MAX_DELIM)) u_close_match (
    .window_i(win_d), .delim_i(cfg_i.close_delim), .len_i(cl), .match_o(m_close)
  );

  // class of the line just finished
  always_comb begin
    if (in_block_q) begin
      if (!seen_q) begin
        cls = cmtc_pkg::CLS_BLANK;   next_block = 1'b1;
      end else if (!close_q) begin
        cls = cmtc_pkg::CLS_COMMENT; next_block = 1'b1;
      end else begin
        cls = tac_q ? cmtc_pkg::CLS_CODE : cmtc_pkg::CLS_COMMENT;
        next_block = 1'b0;
      end
    end else if (pline_q) begin
      cls = cmtc_pkg::CLS_COMMENT;   next_block = 1'b0;
    end else if (popen_q) begin
      if (!close_q) begin
        cls = cmtc_pkg::CLS_COMMENT; next_block = 1'b1;
      end else begin
        cls = tac_q ? cmtc_pkg::CLS_CODE : cmtc_pkg::CLS_COMMENT;
        next_block = 1'b0;
      end
    end else if (open_q) begin
      cls = cmtc_pkg::CLS_CODE;      next_block = !close_q;
    end else begin
      cls = seen_q ? cmtc_pkg::CLS_CODE : cmtc_pkg::CLS_BLANK;
      next_block = 1'b0;
    end
  end

  always_comb begin
    in_block_d = in_block_q;
    seen_d     = seen_q;
    lead_d     = lead_q;
    pline_d    = pline_q;
    popen_d    = popen_q;
    open_d     = open_q;
    since_d    = since_q;
    close_d    = close_q;
    tac_d      = tac_q;
    blank_d    = blank_q;
    comment_d  = comment_q;
    code_d     = code_q;
    res_valid_o = 1'b0;
    unique case (cmtc_pkg::op_e'(op_i))
      cmtc_pkg::OP_TEXT: begin
        if (seen_q || !ws) begin
          seen_d = 1'b1;
          lead_d = (lead_q == cmtc_pkg::SAT_MAX) ? lead_q : lead_q + 1'b1;
          if (close_q && !ws) tac_d = 1'b1;
          if (lead_d == SW'(pl) && m_line) pline_d = 1'b1;
          if (in_block_q) begin
            if (!close_q && lead_d >= SW'(cl) && m_close) close_d = 1'b1;
          end else if (open_q) begin
            since_d = (since_q == cmtc_pkg::SAT_MAX) ? since_q : since_q + 1'b1;
            if (!close_q && since_d >= SW'(cl) && m_close) close_d = 1'b1;
          end else if (cfg_i.block_enabled && lead_d >= SW'(ol) && m_open) begin
            open_d  = 1'b1;
            since_d = '0;
            if (lead_d == SW'(ol)) popen_d = 1'b1;
          end
        end
      end
      cmtc_pkg::OP_EOL: begin
        res_valid_o = 1'b1;
        in_block_d  = next_block;
        case (cls)
          cmtc_pkg::CLS_BLANK:   blank_d   = blank_q + 1'b1;
          cmtc_pkg::CLS_COMMENT: comment_d = comment_q + 1'b1;
          default:               code_d    = code_q + 1'b1;
        endcase
      end
      cmtc_pkg::OP_FILE: begin
        in_block_d = 1'b0;
        blank_d    = '0;
        comment_d  = '0;
        code_d     = '0;
      end
      default: ;
    endcase
  end

  logic line_end;
  assign line_end = (op_i == cmtc_pkg::OP_EOL) || (op_i == cmtc_pkg::OP_FILE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_block_q <= 1'b0;
      win_q      <= '0;
      seen_q     <= 1'b0;
      lead_q     <= '0;
      pline_q    <= 1'b0;
      popen_q    <= 1'b0;
      open_q     <= 1'b0;
      since_q    <= '0;
      close_q    <= 1'b0;
      tac_q      <= 1'b0;
      blank_q    <= '0;
      comment_q  <= '0;
      code_q     <= '0;
    end else if (step_i) begin
      in_block_q <= in_block_d;
      blank_q    <= blank_d;
      comment_q  <= comment_d;
      code_q     <= code_d;
      if (line_end) begin
        // partial line state starts over
        win_q   <= '0;
        seen_q  <= 1'b0;
        lead_q  <= '0;
        pline_q <= 1'b0;
        popen_q <= 1'b0;
        open_q  <= 1'b0;
        since_q <= '0;
        close_q <= 1'b0;
        tac_q   <= 1'b0;
      end else if (op_i == cmtc_pkg::OP_TEXT) begin
        win_q   <= win_d;
        seen_q  <= seen_d;
        lead_q  <= lead_d;
        pline_q <= pline_d;
        popen_q <= popen_d;
        open_q  <= open_d;
        since_q <= since_d;
        close_q <= close_d;
        tac_q   <= tac_d;
      end
    end
  end

  // totals wrap at the counter width and show as 32 bits
  assign blank_x   = {{TW{1'b0}}, blank_d};
  assign comment_x = {{TW{1'b0}}, comment_d};
  assign code_x    = {{TW{1'b0}}, code_d};

  assign res_o.line_class    = cls;
  assign res_o.in_block      = next_block;
  assign res_o.blank_total   = blank_x[TW-1:0];
  assign res_o.comment_total = comment_x[TW-1:0];
  assign res_o.code_total    = code_x[TW-1:0];

endmodule

@@ test/tb.sv @@
// self-checking testbench for the comment line classifier
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_SPARE = 2'd3;        // unused op, block ignores it
  localparam logic [cmtc_pkg::IDX_WIDTH-1:0] REG_NONE = 3'd7;
  localparam int unsigned PER_PHASE = 250;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    logic [1:0]        op;
    logic [7:0]        ch;
    bit                typed;
    cmtc_pkg::result_t want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [7:0] s_char = '0;
  logic [1:0] s_op = cmtc_pkg::OP_TEXT;
  logic m_ready = 1'b1;
  logic cfg_we = 1'b0;
  logic [cmtc_pkg::IDX_WIDTH-1:0] cfg_idx = '0;
  logic [cmtc_pkg::REG_WIDTH-1:0] cfg_data = '0;

  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [cmtc_pkg::RES_T_WIDTH-1:0] m_axis_tdata_o;

  comment_line_classifier DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_char),           // character
    .s_axis_tuser_i  (s_op),             // op
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // class, in_block, blank, comment, code
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // shadow registers and line state of the classifier
  cmtc_pkg::cfg_t regs;
  bit in_blk, seen, pfx_hit, open_first, opened, closed, tail_text;
  logic [63:0] win;
  logic [cmtc_pkg::SAT_WIDTH-1:0] lead, since;
  logic [31:0] n_blank, n_comment, n_code;

  cmtc_pkg::result_t lines_due[$];
  step_t plan_q[$];
  int err_cnt = 0;
  int cyc_cnt = 0;
  int unsigned sent = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;
  bit tail_run = 1'b0;

  function automatic int unsigned clamp_len(logic [cmtc_pkg::LEN_WIDTH-1:0] len);
    return (len > cmtc_pkg::DEF_MAX_DELIM) ? cmtc_pkg::DEF_MAX_DELIM : int'(len);
  endfunction

  // newest len bytes of the window against a delimiter, oldest byte lowest
  function automatic bit delim_hit(logic [63:0] delim, int unsigned len);
    logic [63:0] mask;
    if (len == 0) return 1'b0;
    mask = {64{1'b1}} >> (64 - 8 * len);
    return ((win >> (64 - 8 * len)) & mask) == (delim & mask);
  endfunction

  function automatic void clear_line();
    seen = 1'b0;
    pfx_hit = 1'b0;
    open_first = 1'b0;
    opened = 1'b0;
    closed = 1'b0;
    tail_text = 1'b0;
    lead = '0;
    since = '0;
    win = '0;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    bit ws;
    int unsigned pl, ol, cl;
    ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    pl = clamp_len(regs.line_prefix_len);
    ol = clamp_len(regs.open_len);
    cl = clamp_len(regs.close_len);
    win = {c, win[63:8]};
    if (!seen && ws) return;
    seen = 1'b1;
    if (lead != cmtc_pkg::SAT_MAX) lead++;
    if (closed && !ws) tail_text = 1'b1;
    if (pl != 0 && lead == pl && delim_hit(regs.line_prefix, pl)) pfx_hit = 1'b1;
    if (in_blk) begin
      if (!closed && cl != 0 && lead >= cl && delim_hit(regs.close_delim, cl)) closed = 1'b1;
    end else if (opened) begin
      if (since != cmtc_pkg::SAT_MAX) since++;
      // close search starts after the opening match so the two never overlap
      if (!closed && cl != 0 && since >= cl && delim_hit(regs.close_delim, cl)) closed = 1'b1;
    end else if (regs.block_enabled && ol != 0 && lead >= ol &&
                 delim_hit(regs.open_delim, ol)) begin
      opened = 1'b1;
      since = '0;
      if (lead == ol) open_first = 1'b1;
    end
  endfunction

  function automatic cmtc_pkg::result_t close_line();
    cmtc_pkg::result_t r;
    cmtc_pkg::class_e k;
    bit nb;
    if (in_blk) begin
      if (!seen) begin
        k = cmtc_pkg::CLS_BLANK;
        nb = 1'b1;
      end else if (!closed) begin
        k = cmtc_pkg::CLS_COMMENT;
        nb = 1'b1;
      end else begin
        k = tail_text ? cmtc_pkg::CLS_CODE : cmtc_pkg::CLS_COMMENT;
        nb = 1'b0;
      end
    end else if (pfx_hit) begin
      k = cmtc_pkg::CLS_COMMENT;
      nb = 1'b0;
    end else if (open_first) begin
      if (!closed) begin
        k = cmtc_pkg::CLS_COMMENT;
        nb = 1'b1;
      end else begin
        k = tail_text ? cmtc_pkg::CLS_CODE : cmtc_pkg::CLS_COMMENT;
        nb = 1'b0;
      end
    end else if (opened) begin
      k = cmtc_pkg::CLS_CODE;
      nb = !closed;
    end else begin
      k = seen ? cmtc_pkg::CLS_CODE : cmtc_pkg::CLS_BLANK;
      nb = 1'b0;
    end
    case (k)
      cmtc_pkg::CLS_BLANK:   n_blank++;
      cmtc_pkg::CLS_COMMENT: n_comment++;
      default:               n_code++;
    endcase
    in_blk = nb;
    clear_line();
    r.line_class = k;
    r.in_block = nb;
    r.blank_total = n_blank;
    r.comment_total = n_comment;
    r.code_total = n_code;
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // drive one word and wait for its handshake, then update the prediction
  task automatic send_word(input logic [1:0] op, input logic [7:0] ch,
                           input bit typed, input cmtc_pkg::result_t want);
    int gap;
    cmtc_pkg::result_t line;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_op <= op;
    s_char <= ch;
    do @(posedge clk_i); while (!s_axis_tready_o);
    case (op)
      cmtc_pkg::OP_TEXT: scan_char(ch);
      cmtc_pkg::OP_EOL: begin
        line = close_line();
        lines_due.push_back(typed ? want : line);
      end
      cmtc_pkg::OP_FILE: begin
        in_blk = 1'b0;
        clear_line();
        n_blank = '0;
        n_comment = '0;
        n_code = '0;
      end
      default: ;
    endcase
    if (op != OP_SPARE) sent++;
  endtask

  task automatic send_text(input logic [7:0] c);
    send_word(cmtc_pkg::OP_TEXT, c, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // small alphabet so that delimiters turn up in random text
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0: return "/";
      1: return "*";
      2: return "#";
      3: return "-";
      4: return "!";
      5: return ";";
      6: return "%";
      7: return " ";
      8: return "a";
      9: return "x";
      10: return "(";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] pick_delim();
    logic [63:0] d;
    d = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) != 0) d[8*i +: 8] = pick_char();
    end
    return d;
  endfunction

  // a delimiter as configured, now and then cut short by one byte
  task automatic send_piece(input logic [63:0] v, input logic [cmtc_pkg::LEN_WIDTH-1:0] len);
    int unsigned k;
    k = clamp_len(len);
    if (k != 0 && $urandom_range(0, 7) == 0) k--;
    for (int i = 0; i < k; i++) send_text(v[8*i +: 8]);
  endtask

  task automatic send_body();
    repeat ($urandom_range(0, 4)) send_text(pick_char());
  endtask

  task automatic send_line();
    if (!tail_run && $urandom_range(0, 39) == 0) idle_on = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 2)) send_text(pick_space());
    case ($urandom_range(0, 9))
      0, 1: begin
        send_piece(regs.line_prefix, regs.line_prefix_len);
        send_body();
      end
      2, 3: begin
        send_piece(regs.open_delim, regs.open_len);
        send_body();
        if ($urandom_range(0, 1) == 1) begin
          send_piece(regs.close_delim, regs.close_len);
          send_body();
        end
      end
      4: begin
        send_body();
        send_piece(regs.open_delim, regs.open_len);
        send_body();
        if ($urandom_range(0, 1) == 1) send_piece(regs.close_delim, regs.close_len);
      end
      5: begin
        send_piece(regs.close_delim, regs.close_len);
        send_body();
      end
      6: ;
      default: send_body();
    endcase
    repeat ($urandom_range(0, 2)) send_text(pick_space());
    send_word(cmtc_pkg::OP_EOL, 8'($urandom), 1'b0, '0);
    case ($urandom_range(0, 39))
      0: send_word(cmtc_pkg::OP_FILE, 8'($urandom), 1'b0, '0);
      1: send_word(OP_SPARE, 8'($urandom), 1'b0, '0);
      default: ;
    endcase
  endtask

  // stop sending, let every line result come out, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cmtc_pkg::IDX_WIDTH-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      cmtc_pkg::REG_LINE_PREFIX:     regs.line_prefix = data;
      cmtc_pkg::REG_LINE_PREFIX_LEN: regs.line_prefix_len = data[cmtc_pkg::LEN_WIDTH-1:0];
      cmtc_pkg::REG_OPEN_DELIM:      regs.open_delim = data;
      cmtc_pkg::REG_OPEN_LEN:        regs.open_len = data[cmtc_pkg::LEN_WIDTH-1:0];
      cmtc_pkg::REG_CLOSE_DELIM:     regs.close_delim = data;
      cmtc_pkg::REG_CLOSE_LEN:       regs.close_len = data[cmtc_pkg::LEN_WIDTH-1:0];
      cmtc_pkg::REG_BLOCK_ENABLED:   regs.block_enabled = data[0];
      default: ;
    endcase
  endtask

  task automatic set_phase(input int p);
    logic [63:0] pfx, pl, od, ol, cd, cl, be;
    pfx = pick_delim();
    od = pick_delim();
    cd = pick_delim();
    // length and flag registers get junk above their width, except in phase 7
    pl = {$urandom, $urandom};
    ol = {$urandom, $urandom};
    cl = {$urandom, $urandom};
    be = {$urandom, $urandom};
    pl[3:0] = 4'($urandom_range(1, 8));
    ol[3:0] = 4'($urandom_range(1, 8));
    cl[3:0] = 4'($urandom_range(1, 8));
    be[0] = 1'b1;
    case (p)
      2: begin
        pl[3:0] = 4'd0;
        ol[3:0] = 4'd8;
        cl[3:0] = 4'd8;
      end
      3: ol[3:0] = 4'd0;
      4: begin
        cl[3:0] = 4'd0;
        ol[3:0] = 4'd1;
      end
      5: begin
        be[0] = 1'b0;
        pl[3:0] = 4'd15;
        ol[3:0] = 4'd15;
        cl[3:0] = 4'd15;
      end
      6: begin
        pfx = '0;
        pl[3:0] = 4'd8;
        od = '1;
        ol[3:0] = 4'd8;
        cd = '0;
        cl[3:0] = 4'd15;
      end
      7: begin
        pfx = 64'h2F2F;
        pl = 64'd2;
        od = 64'h2A2F;
        ol = 64'd2;
        cd = 64'h2F2A;
        cl = 64'd2;
        be = 64'd1;
        write_reg(REG_NONE, {$urandom, $urandom});
      end
      default: ;
    endcase
    write_reg(cmtc_pkg::REG_LINE_PREFIX, pfx);
    write_reg(cmtc_pkg::REG_LINE_PREFIX_LEN, pl);
    write_reg(cmtc_pkg::REG_OPEN_DELIM, od);
    write_reg(cmtc_pkg::REG_OPEN_LEN, ol);
    write_reg(cmtc_pkg::REG_CLOSE_DELIM, cd);
    write_reg(cmtc_pkg::REG_CLOSE_LEN, cl);
    write_reg(cmtc_pkg::REG_BLOCK_ENABLED, be);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic void plan_word(logic [1:0] op, logic [7:0] ch);
    step_t s;
    s.op = op;
    s.ch = ch;
    s.typed = 1'b0;
    s.want = '0;
    plan_q.push_back(s);
  endfunction

  function automatic void plan_line(cmtc_pkg::class_e k, bit inb, int b, int c, int d);
    step_t s;
    s.op = cmtc_pkg::OP_EOL;
    s.ch = 8'h00;
    s.typed = 1'b1;
    s.want.line_class = k;
    s.want.in_block = inb;
    s.want.blank_total = b;
    s.want.comment_total = c;
    s.want.code_total = d;
    plan_q.push_back(s);
  endfunction

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) hold_left <= $urandom_range(1, 9);
    end
  end

  always @(posedge clk_i) begin : take_line
    cmtc_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = m_axis_tdata_o[cmtc_pkg::RES_WIDTH-1:0];
      if (lines_due.size() == 0) begin
        $display("%0t: line result expected none got %h", $time, got);
        err_cnt++;
      end else begin
        want = lines_due.pop_front();
        check_field("line_class", 32'(want.line_class), 32'(got.line_class));
        check_field("in_block", 32'(want.in_block), 32'(got.in_block));
        check_field("blank_total", want.blank_total, got.blank_total);
        check_field("comment_total", want.comment_total, got.comment_total);
        check_field("code_total", want.code_total, got.code_total);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    regs.line_prefix = 64'h2F2F;
    regs.line_prefix_len = 4'd2;
    regs.open_delim = 64'h2A2F;
    regs.open_len = 4'd2;
    regs.close_delim = 64'h2F2A;
    regs.close_len = 4'd2;
    regs.block_enabled = 1'b1;
    in_blk = 1'b0;
    clear_line();
    n_blank = '0;
    n_comment = '0;
    n_code = '0;

    // default delimiters: // line, /* */ block
    plan_line(cmtc_pkg::CLS_BLANK, 1'b0, 1, 0, 0);
    plan_word(cmtc_pkg::OP_TEXT, 8'h20);
    plan_word(cmtc_pkg::OP_TEXT, 8'h0D);
    plan_line(cmtc_pkg::CLS_BLANK, 1'b0, 2, 0, 0);
    plan_word(cmtc_pkg::OP_TEXT, "/");
    plan_word(cmtc_pkg::OP_TEXT, "/");
    plan_word(cmtc_pkg::OP_TEXT, "x");
    plan_line(cmtc_pkg::CLS_COMMENT, 1'b0, 2, 1, 0);
    plan_word(cmtc_pkg::OP_TEXT, "a");
    plan_line(cmtc_pkg::CLS_CODE, 1'b0, 2, 1, 1);
    plan_word(cmtc_pkg::OP_TEXT, "/");
    plan_word(cmtc_pkg::OP_TEXT, "*");
    plan_line(cmtc_pkg::CLS_COMMENT, 1'b1, 2, 2, 1);
    // block closes, then text follows on the same line
    plan_word(cmtc_pkg::OP_TEXT, "*");
    plan_word(cmtc_pkg::OP_TEXT, "/");
    plan_word(cmtc_pkg::OP_TEXT, "x");
    plan_line(cmtc_pkg::CLS_CODE, 1'b0, 2, 2, 2);
    plan_word(OP_SPARE, 8'hFF);
    plan_word(cmtc_pkg::OP_TEXT, 8'hFF);
    plan_word(cmtc_pkg::OP_TEXT, 8'h00);
    plan_line(cmtc_pkg::CLS_CODE, 1'b0, 2, 2, 3);
    plan_word(cmtc_pkg::OP_FILE, 8'h00);
    plan_line(cmtc_pkg::CLS_BLANK, 1'b0, 1, 0, 0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[i]) send_word(plan_q[i].op, plan_q[i].ch, plan_q[i].typed, plan_q[i].want);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        drain();
        set_phase(p);
      end
      if (p == N_PHASES - 1) begin
        tail_run = 1'b1;
        idle_on = 1'b0;
      end
      while (sent < (p + 1) * PER_PHASE) send_line();
    end
    drain();
    if (err_cnt == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
